// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition on one edge implies another on the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/cia_pkg.sv -----
// Types, codes and helper functions of the checked integer ALU.
package cia_pkg;

   typedef enum logic [3:0] {
      CMD_ADD  = 4'd0,
      CMD_SUB  = 4'd1,
      CMD_MUL  = 4'd2,
      CMD_DIV  = 4'd3,
      CMD_MOD  = 4'd4,
      CMD_WADD = 4'd5,
      CMD_WSUB = 4'd6,
      CMD_EQ   = 4'd7,
      CMD_NE   = 4'd8,
      CMD_LT   = 4'd9,
      CMD_GT   = 4'd10,
      CMD_LE   = 4'd11,
      CMD_GE   = 4'd12,
      CMD_NEG  = 4'd13
   } cmd_type;

   localparam logic [1:0] WC_8  = 2'd0;
   localparam logic [1:0] WC_16 = 2'd1;
   localparam logic [1:0] WC_32 = 2'd2;
   localparam logic [1:0] WC_64 = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   localparam int DIV_STEPS = 64;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [1:0]  wc;
      logic        uns;
      logic [63:0] hi;
      logic [63:0] lo;
      logic        neg;
      logic [63:0] bits;
      logic [1:0]  status;
      logic        checked;
      logic        a_neg;
      logic        b_neg;
   } info_type;

   typedef struct packed {
      logic        hi;
      logic [63:0] lo;
      logic        neg;
   } sum_type;

   // Reduce to the operand width, then sign- or zero-extend to 64 bits.
   function automatic logic [63:0] fit_width(input logic [63:0] x, input logic [1:0] wc,
                                             input logic uns);
      logic [63:0] v;
      case (wc)
         WC_8:    v = uns ? {56'd0, x[7:0]}  : {{56{x[7]}}, x[7:0]};
         WC_16:   v = uns ? {48'd0, x[15:0]} : {{48{x[15]}}, x[15:0]};
         WC_32:   v = uns ? {32'd0, x[31:0]} : {{32{x[31]}}, x[31:0]};
         default: v = x;
      endcase
      return v;
   endfunction

   // Signed-magnitude add of two 64-bit magnitudes.
   function automatic sum_type add_exact(input logic [63:0] am, input logic an,
                                         input logic [63:0] bm, input logic bn);
      sum_type     r;
      logic [64:0] sum;
      logic [64:0] diff;
      sum  = {1'b0, am} + {1'b0, bm};
      diff = {1'b0, am} - {1'b0, bm};
      if (an == bn) begin
         r.hi  = sum[64];
         r.lo  = sum[63:0];
         r.neg = an;
      end else if (!diff[64]) begin
         r.hi  = 1'b0;
         r.lo  = diff[63:0];
         r.neg = an;
      end else begin
         r.hi  = 1'b0;
         r.lo  = 64'd0 - diff[63:0];
         r.neg = bn;
      end
      return r;
   endfunction

   // True when the exact value fits the operand type.
   function automatic logic fits(input logic [63:0] hi, input logic [63:0] lo, input logic neg,
                                 input logic [1:0] wc, input logic uns);
      logic [63:0] half;
      logic        neg_e;
      logic        ok;
      case (wc)
         WC_8:    half = 64'd1 << 7;
         WC_16:   half = 64'd1 << 15;
         WC_32:   half = 64'd1 << 31;
         default: half = 64'd1 << 63;
      endcase
      neg_e = neg && (lo != 64'd0);
      if (hi != 64'd0) begin
         ok = 1'b0;
      end else if (neg_e) begin
         ok = !uns && (lo <= half);
      end else if (uns) begin
         ok = (wc == WC_64) || (lo < (half << 1));
      end else begin
         ok = lo < half;
      end
      return ok;
   endfunction

endpackage

// ----- design/checked_integer_alu.sv -----
// Top level of the checked integer ALU: a fixed-latency pipeline with a pipelined restoring divider.
//
// Channel   Ports                                   Direction  Handshake
// request   req_command/width_code/is_unsigned/a/b  in         start & !busy
// response  rsp_result_bits, rsp_status             out        rsp_strobe, one cycle
//
// Every request passes stages 1 to 4, the divider stages and the final stage to rsp_strobe, one request per cycle.
// The divider has 64 pipeline stages, one quotient bit each.
// All commands run through the same stages so responses leave in request order.
// Synchronous reset empties the pipeline; busy stays low, as nothing stalls.
module checked_integer_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_command,
   input  logic [1:0]  req_width_code,
   input  logic        req_is_unsigned,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_strobe,
   output logic [63:0] rsp_result_bits,
   output logic [1:0]  rsp_status
);
   import cia_pkg::*;
   `include "assert_macros.svh"

   // stage 1: request registers
   logic        v1_ff;
   logic [3:0]  cmd1_ff;
   logic [1:0]  wc1_ff;
   logic        uns1_ff;
   logic [63:0] a1_ff;
   logic [63:0] b1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & !busy;
      end
      cmd1_ff <= req_command;
      wc1_ff  <= req_width_code;
      uns1_ff <= req_is_unsigned;
      a1_ff   <= req_operand_a;
      b1_ff   <= req_operand_b;
   end

   // stage 2: fit operands and split into sign and magnitude
   logic [63:0] va_in, vb_in;
   logic        an_in, bn_in;
   logic        v2_ff;
   logic [3:0]  cmd2_ff;
   logic [1:0]  wc2_ff;
   logic        uns2_ff;
   logic [63:0] va2_ff, vb2_ff, am2_ff, bm2_ff;
   logic        an2_ff, bn2_ff;

   always_comb begin
      va_in = fit_width(a1_ff, wc1_ff, uns1_ff);
      vb_in = fit_width(b1_ff, wc1_ff, uns1_ff);
      an_in = !uns1_ff && va_in[63];
      bn_in = !uns1_ff && vb_in[63];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      cmd2_ff <= cmd1_ff;
      wc2_ff  <= wc1_ff;
      uns2_ff <= uns1_ff;
      va2_ff  <= va_in;
      vb2_ff  <= vb_in;
      an2_ff  <= an_in;
      bn2_ff  <= bn_in;
      am2_ff  <= an_in ? 64'd0 - va_in : va_in;
      bm2_ff  <= bn_in ? 64'd0 - vb_in : vb_in;
   end

   // stage 3: add, compare, wrap, negate, partial products
   info_type    info3_in;
   sum_type     sum3;
   logic        lt3, eq3;
   logic        v3_ff;
   info_type    info3_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [63:0] am3_ff, bm3_ff;

   always_comb begin
      sum3 = add_exact(am2_ff, an2_ff, bm2_ff,
                       (cmd2_ff == CMD_SUB) ? !bn2_ff : bn2_ff);
      eq3  = va2_ff == vb2_ff;
      lt3  = uns2_ff ? (va2_ff < vb2_ff) : ($signed(va2_ff) < $signed(vb2_ff));
      info3_in         = '0;
      info3_in.cmd     = cmd2_ff;
      info3_in.wc      = wc2_ff;
      info3_in.uns     = uns2_ff;
      info3_in.status  = ST_OK;
      info3_in.a_neg   = an2_ff;
      info3_in.b_neg   = bn2_ff;
      case (cmd2_ff)
         CMD_ADD, CMD_SUB: begin
            info3_in.hi      = {63'd0, sum3.hi};
            info3_in.lo      = sum3.lo;
            info3_in.neg     = sum3.neg;
            info3_in.checked = 1'b1;
         end
         CMD_MUL, CMD_DIV, CMD_MOD: info3_in.checked = 1'b1;
         CMD_WADD: info3_in.bits = fit_width(va2_ff + vb2_ff, wc2_ff, uns2_ff);
         CMD_WSUB: info3_in.bits = fit_width(va2_ff - vb2_ff, wc2_ff, uns2_ff);
         CMD_EQ:   info3_in.bits = {63'd0, eq3};
         CMD_NE:   info3_in.bits = {63'd0, !eq3};
         CMD_LT:   info3_in.bits = {63'd0, lt3};
         CMD_GT:   info3_in.bits = {63'd0, !lt3 && !eq3};
         CMD_LE:   info3_in.bits = {63'd0, lt3 || eq3};
         CMD_GE:   info3_in.bits = {63'd0, !lt3};
         CMD_NEG: begin
            info3_in.lo      = am2_ff;
            info3_in.neg     = !an2_ff;
            info3_in.checked = 1'b1;
         end
         default: info3_in.checked = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      info3_ff <= info3_in;
      am3_ff   <= am2_ff;
      bm3_ff   <= bm2_ff;
      p00_ff   <= {32'd0, am2_ff[31:0]}  * {32'd0, bm2_ff[31:0]};
      p01_ff   <= {32'd0, am2_ff[31:0]}  * {32'd0, bm2_ff[63:32]};
      p10_ff   <= {32'd0, am2_ff[63:32]} * {32'd0, bm2_ff[31:0]};
      p11_ff   <= {32'd0, am2_ff[63:32]} * {32'd0, bm2_ff[63:32]};
   end

   // stage 4: sum partial products, catch zero divisor, load divider
   info_type     info4_in;
   logic [127:0] prod4;
   logic         vld_ff  [0:DIV_STEPS];
   info_type     info_ff [0:DIV_STEPS];
   logic [63:0]  dq_ff   [0:DIV_STEPS];
   logic [63:0]  rem_ff  [0:DIV_STEPS];
   logic [63:0]  dvs_ff  [0:DIV_STEPS];

   always_comb begin
      prod4 = {p11_ff, p00_ff} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0};
      info4_in = info3_ff;
      if (info3_ff.cmd == CMD_MUL) begin
         info4_in.hi  = prod4[127:64];
         info4_in.lo  = prod4[63:0];
         info4_in.neg = info3_ff.a_neg ^ info3_ff.b_neg;
      end
      if ((info3_ff.cmd == CMD_DIV || info3_ff.cmd == CMD_MOD) && bm3_ff == 64'd0) begin
         info4_in.status  = ST_DIV0;
         info4_in.checked = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= v3_ff;
      end
      info_ff[0] <= info4_in;
      dq_ff[0]   <= am3_ff;
      rem_ff[0]  <= 64'd0;
      dvs_ff[0]  <= bm3_ff;
   end

   // restoring divider: one quotient bit per stage, dividend shifts out as quotient shifts in
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [64:0] trial;
      logic [64:0] diff;
      logic        ge;

      always_comb begin
         trial = {rem_ff[j], dq_ff[j][63]};
         diff  = trial - {1'b0, dvs_ff[j]};
         ge    = !diff[64];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else begin
            vld_ff[j+1] <= vld_ff[j];
         end
         info_ff[j+1] <= info_ff[j];
         dvs_ff[j+1]  <= dvs_ff[j];
         dq_ff[j+1]   <= {dq_ff[j][62:0], ge};
         rem_ff[j+1]  <= ge ? diff[63:0] : trial[63:0];
      end
   end

   // final stage: pick quotient or remainder, range check
   info_type    fin;
   logic [63:0] bits_in;
   logic [1:0]  status_in;
   logic        strobe_ff;
   logic [63:0] bits_ff;
   logic [1:0]  status_ff;

   always_comb begin
      fin = info_ff[DIV_STEPS];
      case (fin.cmd)
         CMD_DIV: begin
            fin.lo  = dq_ff[DIV_STEPS];
            fin.neg = fin.a_neg ^ fin.b_neg;
         end
         CMD_MOD: begin
            fin.lo  = rem_ff[DIV_STEPS];
            fin.neg = fin.a_neg;
         end
         default: fin.neg = fin.neg;
      endcase
      bits_in   = fin.bits;
      status_in = fin.status;
      if (fin.checked) begin
         if (fits(fin.hi, fin.lo, fin.neg, fin.wc, fin.uns)) begin
            bits_in = fin.neg ? 64'd0 - fin.lo : fin.lo;
         end else begin
            bits_in   = 64'd0;
            status_in = ST_OVF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[DIV_STEPS];
      end
      bits_ff   <= bits_in;
      status_ff <= status_in;
   end

   assign busy            = 1'b0;
   assign rsp_strobe      = strobe_ff;
   assign rsp_result_bits = bits_ff;
   assign rsp_status      = status_ff;

   `ASSERT_IMPL(a_status_range, rsp_strobe, rsp_status != 2'd3, "status code out of range")
   `ASSERT_IMPL(a_fault_zero, rsp_strobe && rsp_status != ST_OK, rsp_result_bits == 64'd0,
                "fault response carries nonzero result")
   `ASSERT_NEXT(a_cmp_bool, vld_ff[DIV_STEPS] && fin.cmd >= CMD_EQ && fin.cmd <= CMD_GE,
                rsp_strobe && rsp_result_bits[63:1] == 63'd0, "compare result not 0 or 1")
   `ASSERT_NEXT(a_div0, vld_ff[0] && (info_ff[0].cmd == CMD_DIV || info_ff[0].cmd == CMD_MOD)
                && dvs_ff[0] == 64'd0, info_ff[1].status == ST_DIV0 && !info_ff[1].checked,
                "zero divisor not flagged")

endmodule

// ----- verif/checked_integer_alu_tb.sv -----
// Self-checking testbench for the checked integer ALU: directed and random requests.
`timescale 1ns / 1ps

module checked_integer_alu_tb;
   import cia_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;

   // command codes that decode to no operation
   localparam logic [3:0] CMD_SPARE_LO = 4'd14;
   localparam logic [3:0] CMD_SPARE_HI = 4'd15;

   typedef struct {
      logic [63:0] bits;
      logic [1:0]  status;
   } alu_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_command;
   logic [1:0]  req_width_code;
   logic        req_is_unsigned;
   logic [63:0] req_operand_a;
   logic [63:0] req_operand_b;
   logic        rsp_strobe;
   logic [63:0] rsp_result_bits;
   logic [1:0]  rsp_status;

   alu_result_type pending_results[$];
   int unsigned mismatches;
   int unsigned idle_cycles;
   bit          no_gaps;

   checked_integer_alu dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_width_code(req_width_code),
      .req_is_unsigned(req_is_unsigned), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .rsp_strobe(rsp_strobe),
      .rsp_result_bits(rsp_result_bits), .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Reduce to the operand width, then sign- or zero-extend.
   function automatic logic [63:0] trim_operand(logic [63:0] x, logic [1:0] wc, logic uns);
      int          w;
      logic [63:0] mask;
      w = 8 << wc;
      mask = (wc == WC_64) ? '1 : ((64'd1 << w) - 64'd1);
      if (!uns && x[w-1]) return x | ~mask;
      return x & mask;
   endfunction

   function automatic logic signed [129:0] exact_value(logic [63:0] x, logic [1:0] wc,
                                                      logic uns);
      logic [63:0] f;
      f = trim_operand(x, wc, uns);
      if (uns) return $signed({66'd0, f});
      return $signed({{66{f[63]}}, f});
   endfunction

   function automatic alu_result_type compute_alu(logic [3:0] cmd, logic [1:0] wc, logic uns,
                                                  logic [63:0] a_raw, logic [63:0] b_raw);
      alu_result_type          res;
      logic signed [129:0]     a;
      logic signed [129:0]     b;
      logic signed [129:0]     r;
      logic signed [129:0]     one;
      logic signed [129:0]     lo_lim;
      logic signed [129:0]     hi_lim;
      int                      w;
      bit                      checked;
      w = 8 << wc;
      one = 130'sd1;
      a = exact_value(a_raw, wc, uns);
      b = exact_value(b_raw, wc, uns);
      r = '0;
      checked = 1'b1;
      res.bits = 64'd0;
      res.status = ST_OK;
      case (cmd)
         CMD_ADD: r = a + b;
         CMD_SUB: r = a - b;
         CMD_MUL: r = a * b;
         CMD_DIV, CMD_MOD: begin
            if (b == 0) begin
               res.status = ST_DIV0;
               checked = 1'b0;
            end else if (cmd == CMD_DIV) begin
               r = a / b;
            end else begin
               r = a % b;
            end
         end
         CMD_WADD: begin
            checked = 1'b0;
            res.bits = trim_operand(a_raw + b_raw, wc, uns);
         end
         CMD_WSUB: begin
            checked = 1'b0;
            res.bits = trim_operand(a_raw - b_raw, wc, uns);
         end
         CMD_EQ: begin checked = 1'b0; res.bits = {63'd0, a == b}; end
         CMD_NE: begin checked = 1'b0; res.bits = {63'd0, a != b}; end
         CMD_LT: begin checked = 1'b0; res.bits = {63'd0, a < b}; end
         CMD_GT: begin checked = 1'b0; res.bits = {63'd0, a > b}; end
         CMD_LE: begin checked = 1'b0; res.bits = {63'd0, a <= b}; end
         CMD_GE: begin checked = 1'b0; res.bits = {63'd0, a >= b}; end
         CMD_NEG: r = -a;
         default: checked = 1'b0;
      endcase
      if (checked) begin
         if (uns) begin
            lo_lim = '0;
            hi_lim = (one <<< w) - one;
         end else begin
            lo_lim = -(one <<< (w - 1));
            hi_lim = (one <<< (w - 1)) - one;
         end
         if (r < lo_lim || r > hi_lim) res.status = ST_OVF;
         else res.bits = trim_operand(r[63:0], wc, uns);
      end
      return res;
   endfunction

   // Record each accepted request's expectation and check each response.
   always @(posedge clock) begin
      alu_result_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response bits=%h status=%0d",
                           rsp_result_bits, rsp_status);
            end else begin
               want = pending_results.pop_front();
               if (want.bits !== rsp_result_bits || want.status !== rsp_status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected bits=%h status=%0d, got bits=%h status=%0d",
                              want.bits, want.status, rsp_result_bits, rsp_status);
               end
            end
         end
         if (start && !busy)
            pending_results.push_back(compute_alu(req_command, req_width_code,
                                                  req_is_unsigned, req_operand_a,
                                                  req_operand_b));
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Call just after a rising edge; returns at the edge that accepts the request.
   task automatic send_request(logic [3:0] cmd, logic [1:0] wc, logic uns,
                               logic [63:0] a, logic [63:0] b);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_width_code <= wc;
      req_is_unsigned <= uns;
      req_operand_a <= a;
      req_operand_b <= b;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [63:0] pick_operand(logic [1:0] wc);
      logic [63:0] mask;
      logic [63:0] x;
      int          w;
      w = 8 << wc;
      mask = (wc == WC_64) ? '1 : ((64'd1 << w) - 64'd1);
      case ($urandom_range(0, 9))
         0: x = 64'd0;
         1: x = 64'd1;
         2: x = mask;
         3: x = 64'd1 << (w - 1);
         4: x = (64'd1 << (w - 1)) - 64'd1;
         5: x = 64'd0 - 64'($urandom_range(1, 20));
         6: x = 64'($urandom_range(0, 20));
         7: x = {32'd0, $urandom} >> $urandom_range(0, 31);
         default: x = {$urandom, $urandom};
      endcase
      x &= mask;
      // Garbage above the width must be ignored.
      if ($urandom_range(0, 1)) x |= {$urandom, $urandom} & ~mask;
      return x;
   endfunction

   task automatic test_special_cases();
      send_request(CMD_ADD, WC_8, 1'b0, 64'h7f, 64'h01);
      send_request(CMD_SUB, WC_8, 1'b0, 64'h80, 64'h01);
      send_request(CMD_ADD, WC_64, 1'b1, '1, 64'd1);
      send_request(CMD_SUB, WC_64, 1'b1, 64'd0, 64'd1);
      send_request(CMD_MUL, WC_32, 1'b0, 64'h8000_0000, '1);
      send_request(CMD_MUL, WC_64, 1'b1, '1, '1);
      send_request(CMD_DIV, WC_16, 1'b0, 64'h1234, 64'd0);
      send_request(CMD_MOD, WC_32, 1'b1, 64'd77, 64'hffff_ffff_0000_0000);
      send_request(CMD_DIV, WC_64, 1'b0, 64'h8000_0000_0000_0000, '1);
      send_request(CMD_DIV, WC_8, 1'b0, 64'hf9, 64'h02);
      send_request(CMD_MOD, WC_8, 1'b0, 64'hf9, 64'h02);
      send_request(CMD_WADD, WC_64, 1'b0, '1, '1);
      send_request(CMD_WSUB, WC_16, 1'b1, 64'd0, 64'd1);
      send_request(CMD_EQ, WC_8, 1'b0, 64'hff00_0000_0000_0005, 64'h05);
      send_request(CMD_NE, WC_8, 1'b1, 64'h80, 64'h7f);
      send_request(CMD_LT, WC_8, 1'b0, 64'h80, 64'h7f);
      send_request(CMD_GT, WC_64, 1'b1, '1, 64'd0);
      send_request(CMD_LE, WC_32, 1'b0, 64'hffff_ffff, 64'hffff_ffff);
      send_request(CMD_GE, WC_16, 1'b0, 64'h8000, 64'h7fff);
      send_request(CMD_NEG, WC_64, 1'b0, 64'h8000_0000_0000_0000, '1);
      send_request(CMD_NEG, WC_8, 1'b1, 64'd0, 64'h55);
      send_request(CMD_NEG, WC_32, 1'b1, 64'd3, 64'd0);
      send_request(CMD_SPARE_LO, WC_64, 1'b0, '1, '1);
      send_request(CMD_SPARE_HI, WC_8, 1'b1, 64'd9, 64'd9);
   endtask

   task automatic test_random_mix(int unsigned count);
      logic [1:0] wc;
      for (int unsigned i = 0; i < count; i++) begin
         // Every 50 requests, pick back-to-back or gapped requests at random.
         if (i % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         wc = 2'($urandom_range(0, 3));
         send_request(4'($urandom_range(0, 15)), wc, 1'($urandom_range(0, 1)),
                      pick_operand(wc), pick_operand(wc));
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_ADD;
      req_width_code = WC_8;
      req_is_unsigned = 1'b0;
      req_operand_a = 64'd0;
      req_operand_b = 64'd0;
      mismatches = 0;
      no_gaps = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_random_mix(800);
      start <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/cia_pkg.sv
design/checked_integer_alu.sv
verif/checked_integer_alu_tb.sv
